// ===== src/lcst_pkg.sv =====
// lcst_pkg: shared constants, command codes and types for the cache set tag core
// no dependencies
`default_nettype none

package lcst_pkg;

    localparam int WAYS  = 4;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W = 32;
    localparam int ADDR_W = 32;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_EVICT  = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DIRTY  = 3'd3,
        CMD_INVAL  = 3'd4,
        CMD_TOUCH  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_CLEAN     = 2'd1,
        EV_WRITEBACK = 2'd2
    } t_evict;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef logic [WAY_W-1:0] t_way_id;

    // control broadcast to every way cell during execution
    typedef struct packed {
        logic              en;
        t_cmd              cmd;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] addr;
        logic              any_hit;
        t_way_id           sel_way;
        t_way_id           lru_way;
    } t_way_ctrl;

    // status a way cell reports back
    typedef struct packed {
        logic              match;
        logic              valid;
        logic              dirty;
        logic [ADDR_W-1:0] addr;
    } t_way_stat;

    // control broadcast to every rank cell during execution
    typedef struct packed {
        logic    en;
        logic    touch;
        logic    inval;
        logic    any_hit;
    } t_rank_ctrl;

endpackage

`default_nettype wire

// ===== src/lcst_if.sv =====
// lcst_in_if / lcst_out_if: valid-ready channels for commands and results
// depends on lcst_pkg
`default_nettype none

interface lcst_in_if
    import lcst_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] block_addr;

    modport source (output valid, output command, output tag, output block_addr,
                    input ready);
    modport sink   (input valid, input command, input tag, input block_addr,
                    output ready);
endinterface

interface lcst_out_if
    import lcst_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              found;
    logic [1:0]        evict_status;
    logic [ADDR_W-1:0] victim_addr;

    modport source (output valid, output found, output evict_status,
                    output victim_addr, input ready);
    modport sink   (input valid, input found, input evict_status,
                    input victim_addr, output ready);
endinterface

`default_nettype wire

// ===== src/lcst_way_cell.sv =====
// lcst_way_cell: storage and tag compare of one way (tag, address, valid, dirty)
// depends on lcst_pkg
`default_nettype none

module lcst_way_cell
    import lcst_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_way_id   i_way,
    input  wire t_way_ctrl i_ctrl,
    output t_way_stat      o_stat
);

    logic [TAG_W-1:0]  r_tag;
    logic [ADDR_W-1:0] r_addr;
    logic              r_valid;
    logic              r_dirty;
    logic              is_lru;
    logic              is_sel;
    logic              match;

    assign match  = r_valid && (r_tag == i_ctrl.tag);
    assign is_lru = (i_ctrl.lru_way == i_way);
    assign is_sel = (i_ctrl.sel_way == i_way);

    assign o_stat.match = match;
    assign o_stat.valid = r_valid;
    assign o_stat.dirty = r_dirty;
    assign o_stat.addr  = r_addr;

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en && i_ctrl.cmd == CMD_INSERT && is_lru) begin
            r_tag  <= i_ctrl.tag;
            r_addr <= i_ctrl.addr;
        end
    end

    // flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
        end else if (i_ctrl.en) begin
            case (i_ctrl.cmd)
                CMD_EVICT: begin
                    if (is_lru) begin
                        r_valid <= 1'b0;
                        r_dirty <= 1'b0;
                    end
                end
                CMD_INSERT: begin
                    if (is_lru) begin
                        r_valid <= 1'b1;
                        r_dirty <= 1'b0;
                    end
                end
                CMD_DIRTY: begin
                    if (match) r_dirty <= 1'b1;
                end
                CMD_INVAL: begin
                    if (i_ctrl.any_hit && is_sel) begin
                        r_valid <= 1'b0;
                        r_dirty <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/lcst_rank_cell.sv =====
// lcst_rank_cell: one position of the lru rank chain, holds a way id
// depends on lcst_pkg
`default_nettype none

module lcst_rank_cell
    import lcst_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_way_id    i_pos,
    input  wire t_way_id    i_left,
    input  wire t_way_id    i_right,
    input  wire logic       i_hit_above,
    input  wire logic [WAYS-1:0] i_match,
    input  wire t_rank_ctrl i_ctrl,
    output t_way_id         o_id,
    output logic            o_hit_above,
    output logic            o_first
);

    t_way_id r_id;
    t_way_id n_id;
    logic    my_hit;

    assign my_hit      = i_match[r_id];
    assign o_hit_above = i_hit_above | my_hit;
    assign o_first     = my_hit & ~i_hit_above;
    assign o_id        = r_id;

    // touch: positions up to the hit take from the left (head takes the hit way)
    // invalidate: positions from the hit on take from the right (tail takes it)
    always_comb begin
        n_id = r_id;
        if (i_ctrl.en && i_ctrl.any_hit) begin
            if (i_ctrl.touch && !i_hit_above) n_id = i_left;
            else if (i_ctrl.inval && o_hit_above) n_id = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_id <= i_pos;
        else          r_id <= n_id;
    end

endmodule

`default_nettype wire

// ===== src/lru_cache_set_tags_core.sv =====
// lru_cache_set_tags_core: one cache set with true-lru order, built from a row of
// way cells and a chain of rank cells; depends on lcst_pkg, lcst_if, lcst_way_cell,
// lcst_rank_cell
//
//  port     dir  payload                                  role
//  i_in     in   command[3], tag[32], block_addr[32]      one command per transaction
//  o_out    out  found[1], evict_status[2], victim_addr   one result per command
//
// each command is accepted, then executed (compare, priority, update)
// the next command is accepted the cycle after execution, once the result
// register is free or drained in that cycle
// reset is synchronous, active low: all ways invalid and clean, rank is identity
// a stalled result holds in the output register and blocks new commands
`default_nettype none

module lru_cache_set_tags_core
    import lcst_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lcst_in_if.sink    i_in,
    lcst_out_if.source o_out
);

    t_state r_state;
    t_state n_state;

    // captured command
    t_cmd              r_cmd;
    logic [TAG_W-1:0]  r_tag;
    logic [ADDR_W-1:0] r_addr;

    // result register
    logic              r_out_valid;
    logic              r_found;
    t_evict            r_status;
    logic [ADDR_W-1:0] r_victim;
    logic              n_found;
    t_evict            n_status;
    logic [ADDR_W-1:0] n_victim;

    logic in_ready;
    logic exec_en;
    logic accept;

    // cell interconnect
    t_way_stat        way_stat [WAYS];
    logic [WAYS-1:0]  match_vec;
    t_way_id          rank_id  [WAYS];
    logic [WAYS:0]    hit_chain;
    logic [WAYS-1:0]  first_vec;
    t_way_id          sel_way;
    t_way_id          lru_way;
    logic             any_hit;
    t_way_ctrl        way_ctrl;
    t_rank_ctrl       rank_ctrl;

    assign accept = i_in.valid && in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        in_ready = 1'b0;
        exec_en  = 1'b0;
        case (r_state)
            ST_IDLE: in_ready = !r_out_valid || o_out.ready;
            ST_EXEC: exec_en  = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_in.command);
            r_tag  <= i_in.tag;
            r_addr <= i_in.block_addr;
        end
    end

    // way cells, indexed by way number
    assign lru_way = rank_id[WAYS-1];

    assign way_ctrl.en      = exec_en;
    assign way_ctrl.cmd     = r_cmd;
    assign way_ctrl.tag     = r_tag;
    assign way_ctrl.addr    = r_addr;
    assign way_ctrl.any_hit = any_hit;
    assign way_ctrl.sel_way = sel_way;
    assign way_ctrl.lru_way = lru_way;

    for (genvar w = 0; w < WAYS; w++) begin : g_way
        lcst_way_cell u_way (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_way   (t_way_id'(w)),
            .i_ctrl  (way_ctrl),
            .o_stat  (way_stat[w])
        );
        assign match_vec[w] = way_stat[w].match;
    end

    // rank chain, position 0 is mru; the hit flag ripples from mru toward lru
    assign any_hit = |match_vec;

    assign rank_ctrl.en      = exec_en;
    assign rank_ctrl.touch   = (r_cmd == CMD_TOUCH);
    assign rank_ctrl.inval   = (r_cmd == CMD_INVAL);
    assign rank_ctrl.any_hit = any_hit;

    assign hit_chain[0] = 1'b0;

    for (genvar p = 0; p < WAYS; p++) begin : g_rank
        t_way_id left_id;
        t_way_id right_id;
        // the ends of the chain take the hit way itself
        if (p == 0) begin : g_head
            assign left_id = sel_way;
        end else begin : g_mid_l
            assign left_id = rank_id[p-1];
        end
        if (p == WAYS-1) begin : g_tail
            assign right_id = sel_way;
        end else begin : g_mid_r
            assign right_id = rank_id[p+1];
        end

        lcst_rank_cell u_rank (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_pos       (t_way_id'(p)),
            .i_left      (left_id),
            .i_right     (right_id),
            .i_hit_above (hit_chain[p]),
            .i_match     (match_vec),
            .i_ctrl      (rank_ctrl),
            .o_id        (rank_id[p]),
            .o_hit_above (hit_chain[p+1]),
            .o_first     (first_vec[p])
        );
    end

    // way id of the hit nearest to mru (one-hot select, or-merged)
    always_comb begin
        sel_way = '0;
        for (int p = 0; p < WAYS; p++) begin
            if (first_vec[p]) sel_way = sel_way | rank_id[p];
        end
    end

    // result of the executing command
    always_comb begin
        n_found  = 1'b0;
        n_status = EV_NONE;
        n_victim = '0;
        case (r_cmd)
            CMD_LOOKUP, CMD_DIRTY, CMD_INVAL, CMD_TOUCH: n_found = any_hit;
            CMD_EVICT: begin
                if (way_stat[lru_way].valid) begin
                    n_status = way_stat[lru_way].dirty ? EV_WRITEBACK : EV_CLEAN;
                    n_victim = way_stat[lru_way].addr;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_en) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            r_found  <= n_found;
            r_status <= n_status;
            r_victim <= n_victim;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_found;
    assign o_out.evict_status = r_status;
    assign o_out.victim_addr  = r_victim;

`ifndef NO_ASSERTIONS
    // every accepted command executes in the following cycle
    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("command not executed after accept");

    // execution always leaves a result waiting
    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_en |=> o_out.valid)
        else $error("no result after execution");

    // the rank chain is a permutation: each way sits at exactly one position
    for (genvar w = 0; w < WAYS; w++) begin : g_perm_chk
        logic [WAYS-1:0] at_pos;
        for (genvar p = 0; p < WAYS; p++) begin : g_pos
            assign at_pos[p] = (rank_id[p] == t_way_id'(w));
        end
        a_rank_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            $onehot(at_pos))
            else $error("rank order lost or duplicated a way");
    end

    // a hit report and an eviction report never share a result
    a_found_xor_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.found && (o_out.evict_status != EV_NONE)))
        else $error("result reports both a hit and an eviction");
`endif

endmodule

`default_nettype wire

// ===== test/tb_lru_cache_set_tags_core.sv =====
// tb_lru_cache_set_tags_core: self-checking bench for the true-lru cache set tag core
// depends on lcst_pkg, lcst_in_if, lcst_out_if and lru_cache_set_tags_core
// commands go through a queue-fed driver, results are checked in order by a monitor
`default_nettype none

module tb_lru_cache_set_tags_core;
    import lcst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one command transaction as it is queued for the driver
    typedef struct {
        logic [2:0]        cmd;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] addr;
    } t_set_cmd;

    // one result transaction as the set should report it
    typedef struct packed {
        logic              found;
        t_evict            evict_status;
        logic [ADDR_W-1:0] victim_addr;
    } t_set_result;

    logic i_clk;
    logic i_rst_n;

    lcst_in_if  in_ch ();
    lcst_out_if out_ch ();

    lru_cache_set_tags_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // commands waiting to be driven, results owed by the set
    t_set_cmd    cmd_backlog[$];
    t_set_result owed_results[$];

    // idle and stall percentages of the current phase
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int          err_count;

    // shadow copy of the set: tags, addresses, flags and the rank order (0 = mru)
    logic [TAG_W-1:0]  shadow_tag  [WAYS];
    logic [ADDR_W-1:0] shadow_addr [WAYS];
    bit                shadow_valid[WAYS];
    bit                shadow_dirty[WAYS];
    t_way_id           shadow_rank [WAYS];

    // tags that random traffic mostly draws from, so that matches are frequent
    logic [TAG_W-1:0] tag_pool[8];

    always #6 i_clk = ~i_clk;

    // rank position of the valid matching way nearest to mru, WAYS if none
    function automatic int hit_position(logic [TAG_W-1:0] t);
        int p;
        for (p = 0; p < WAYS; p++) begin
            if (shadow_valid[shadow_rank[p]] && shadow_tag[shadow_rank[p]] == t) begin
                return p;
            end
        end
        return WAYS;
    endfunction

    // apply one command to the shadow set and return the result it reports
    function automatic t_set_result set_access(logic [2:0] cmd, logic [TAG_W-1:0] t,
                                               logic [ADDR_W-1:0] a);
        t_set_result r;
        t_way_id     lru;
        t_way_id     w;
        int          pos;
        int          j;
        r.found        = 1'b0;
        r.evict_status = EV_NONE;
        r.victim_addr  = '0;
        lru = shadow_rank[WAYS-1];
        case (cmd)
            CMD_LOOKUP: begin
                for (j = 0; j < WAYS; j++) begin
                    if (shadow_valid[j] && shadow_tag[j] == t) r.found = 1'b1;
                end
            end
            CMD_EVICT: begin
                // an invalid lru way leaves everything as it is
                if (shadow_valid[lru]) begin
                    r.evict_status    = shadow_dirty[lru] ? EV_WRITEBACK : EV_CLEAN;
                    r.victim_addr     = shadow_addr[lru];
                    shadow_valid[lru] = 1'b0;
                    shadow_dirty[lru] = 1'b0;
                end
            end
            CMD_INSERT: begin
                // overwrites the lru way even when valid and dirty, rank untouched
                shadow_tag[lru]   = t;
                shadow_addr[lru]  = a;
                shadow_valid[lru] = 1'b1;
                shadow_dirty[lru] = 1'b0;
            end
            CMD_DIRTY: begin
                // every valid copy of the tag is marked
                for (j = 0; j < WAYS; j++) begin
                    if (shadow_valid[j] && shadow_tag[j] == t) begin
                        shadow_dirty[j] = 1'b1;
                        r.found         = 1'b1;
                    end
                end
            end
            CMD_INVAL: begin
                pos = hit_position(t);
                if (pos < WAYS) begin
                    r.found         = 1'b1;
                    w               = shadow_rank[pos];
                    shadow_valid[w] = 1'b0;
                    shadow_dirty[w] = 1'b0;
                    for (j = pos; j < WAYS - 1; j++) shadow_rank[j] = shadow_rank[j+1];
                    shadow_rank[WAYS-1] = w;
                end
            end
            CMD_TOUCH: begin
                pos = hit_position(t);
                if (pos < WAYS) begin
                    r.found = 1'b1;
                    w       = shadow_rank[pos];
                    for (j = pos; j > 0; j--) shadow_rank[j] = shadow_rank[j-1];
                    shadow_rank[0] = w;
                end
            end
            default: begin
                // unused codes: no change, all fields zero
            end
        endcase
        return r;
    endfunction

    task automatic queue_cmd(logic [2:0] c, logic [TAG_W-1:0] t, logic [ADDR_W-1:0] a);
        t_set_cmd item;
        item.cmd  = c;
        item.tag  = t;
        item.addr = a;
        cmd_backlog.push_back(item);
    endtask

    // random traffic: mostly insert/touch fills and hits on pooled tags,
    // with some fully random tags and a few unused codes as noise
    task automatic queue_random_ops(int count);
        int               n;
        int unsigned      r;
        logic [TAG_W-1:0] t;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85) t = tag_pool[$urandom_range(0, 7)];
            else t = $urandom;
            if (r < 22) begin
                queue_cmd(CMD_INSERT, t, $urandom);
                // well-formed fill: move the new line to mru so the next insert
                // lands in another way
                if ($urandom_range(0, 99) < 65) begin
                    queue_cmd(CMD_TOUCH, t, $urandom);
                    n++;
                end
            end else if (r < 36) begin
                queue_cmd(CMD_LOOKUP, t, $urandom);
            end else if (r < 48) begin
                queue_cmd(CMD_EVICT, $urandom, $urandom);
            end else if (r < 60) begin
                queue_cmd(CMD_DIRTY, t, $urandom);
            end else if (r < 72) begin
                queue_cmd(CMD_INVAL, t, $urandom);
            end else if (r < 92) begin
                queue_cmd(CMD_TOUCH, t, $urandom);
            end else if (r < 97) begin
                queue_cmd(3'($urandom_range(0, 5)), $urandom, $urandom);
            end else begin
                queue_cmd(3'($urandom_range(6, 7)), $urandom, $urandom);
            end
            n++;
        end
    endtask

    // driver: predicts each accepted transaction, then offers the next one
    always @(posedge i_clk) begin
        t_set_cmd nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                owed_results.push_back(set_access(in_ch.command, in_ch.tag, in_ch.block_addr));
            end
            // a held transaction stays put until it is taken
            if (!in_ch.valid || in_ch.ready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = cmd_backlog.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.command    <= nxt.cmd;
                    in_ch.tag        <= nxt.tag;
                    in_ch.block_addr <= nxt.addr;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result transaction with the oldest owed result
    always @(posedge i_clk) begin
        t_set_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result found=%0b status=%0d victim=%h", $time,
                             out_ch.found, out_ch.evict_status, out_ch.victim_addr);
                    err_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (out_ch.found !== want.found) begin
                        $display("%0t: found expected %0b actual %0b", $time,
                                 want.found, out_ch.found);
                        err_count++;
                    end
                    if (out_ch.evict_status !== want.evict_status) begin
                        $display("%0t: evict_status expected %0d actual %0d", $time,
                                 want.evict_status, out_ch.evict_status);
                        err_count++;
                    end
                    if (out_ch.victim_addr !== want.victim_addr) begin
                        $display("%0t: victim_addr expected %h actual %h", $time,
                                 want.victim_addr, out_ch.victim_addr);
                        err_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // generous ceiling on the whole run
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int i;
        int ph;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.command    = '0;
        in_ch.tag        = '0;
        in_ch.block_addr = '0;
        out_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        err_count        = 0;
        for (i = 0; i < WAYS; i++) begin
            shadow_tag[i]   = '0;
            shadow_addr[i]  = '0;
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
            shadow_rank[i]  = t_way_id'(i);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (i = 0; i < 6; i++) tag_pool[i] = $urandom;
            tag_pool[6] = '0;
            tag_pool[7] = '1;

            if (ph == 0) begin
                // empty set: nothing matches, nothing to evict
                queue_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_EVICT,  32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_DIRTY,  32'h0000_0000, 32'hFFFF_FFFF);
                queue_cmd(CMD_INVAL,  32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_TOUCH,  32'h0000_0000, 32'h0000_0000);
                // unused command codes
                queue_cmd(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                queue_cmd(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                // extreme tags and addresses
                queue_cmd(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
                queue_cmd(CMD_TOUCH,  32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
                // insert over a valid way replaces it silently
                queue_cmd(CMD_INSERT, 32'h1234_5678, 32'hA5A5_A5A5);
                queue_cmd(CMD_TOUCH,  32'h1234_5678, 32'h0000_0000);
                // duplicate tag in a second way
                queue_cmd(CMD_INSERT, 32'h0000_0000, 32'h5A5A_5A5A);
                queue_cmd(CMD_TOUCH,  32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_DIRTY,  32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
                // invalidate hits only the copy nearest mru
                queue_cmd(CMD_INVAL,  32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
                // lru way is now the invalidated one
                queue_cmd(CMD_EVICT,  32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                queue_cmd(CMD_DIRTY,  32'hFFFF_FFFF, 32'h0000_0000);
                queue_cmd(CMD_EVICT,  32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
                queue_cmd(CMD_EVICT,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end
            queue_random_ops(250);

            // sender holds off until the set has answered everything
            while (cmd_backlog.size() != 0 || in_ch.valid || owed_results.size() != 0) begin
                @(negedge i_clk);
            end
        end

        // let any stray transaction show up before the verdict
        repeat (20) @(negedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
